// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/pdmf_pkg.sv
package pdmf_pkg;

    localparam int CHAN_W   = 16;
    localparam int SAMPLE_W = 8;
    localparam int COUNT_W  = 24;

    // Fade ramp length in frames and its log2; the scale step is a shift.
    localparam int FADE_LENGTH = 256;
    localparam int FADE_SHIFT  = 8;
    localparam int GAIN_W      = FADE_SHIFT + 1;

    localparam int INDEX_W = 2;
    localparam int DATA_W  = COUNT_W;

    localparam logic [INDEX_W-1:0] REG_STEREO_MODE  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WIDE_SAMPLES = 2'd1;
    localparam logic [INDEX_W-1:0] REG_FRAME_TOTAL  = 2'd2;

    localparam logic [SAMPLE_W-1:0] SILENCE = 8'd128;

    // Per-frame controls captured together with the channel data.
    typedef struct packed {
        logic              stereo;
        logic              wide;
        logic [GAIN_W-1:0] gain;
        logic              last;
    } fade_t;

    // Load enables for the two pipeline registers.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } stage_ctrl_t;

endpackage

// File: rtl/pdmf_in_if.sv
interface pdmf_in_if;
    logic                        valid;
    logic                        ready;
    logic [pdmf_pkg::CHAN_W-1:0] first_channel;
    logic [pdmf_pkg::CHAN_W-1:0] second_channel;

    modport source (output valid, output first_channel, output second_channel, input ready);
    modport sink (input valid, input first_channel, input second_channel, output ready);
endinterface

// File: rtl/pdmf_out_if.sv
interface pdmf_out_if;
    logic                          valid;
    logic                          ready;
    logic [pdmf_pkg::SAMPLE_W-1:0] out_sample;
    logic                          last_frame;

    modport source (output valid, output out_sample, output last_frame, input ready);
    modport sink (input valid, input out_sample, input last_frame, output ready);
endinterface

// File: rtl/pdmf_frame_ctrl.sv
`include "assert_macros.svh"

module pdmf_frame_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          write_enable,
    input  logic [pdmf_pkg::INDEX_W-1:0]  write_index,
    input  logic [pdmf_pkg::DATA_W-1:0]   write_data,
    input  logic                          advance,
    output pdmf_pkg::fade_t               fade
);

    logic                          stereo_reg;
    logic                          stereo_next;
    logic                          wide_reg;
    logic                          wide_next;
    logic [pdmf_pkg::COUNT_W-1:0]  total_reg;
    logic [pdmf_pkg::COUNT_W-1:0]  total_next;
    logic [pdmf_pkg::COUNT_W-1:0]  index_reg;
    logic [pdmf_pkg::COUNT_W-1:0]  index_next;

    logic [pdmf_pkg::COUNT_W-1:0]  remaining;
    logic [pdmf_pkg::GAIN_W-1:0]   index_clamp;
    logic [pdmf_pkg::GAIN_W-1:0]   remain_clamp;
    logic                          last;

    always_comb
    begin
        stereo_next = stereo_reg;
        wide_next   = wide_reg;
        total_next  = total_reg;
        if (write_enable)
        begin
            case (write_index)
                pdmf_pkg::REG_STEREO_MODE:  stereo_next = write_data[0];
                pdmf_pkg::REG_WIDE_SAMPLES: wide_next   = write_data[0];
                pdmf_pkg::REG_FRAME_TOTAL:  total_next  = write_data[pdmf_pkg::COUNT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Frames left in the stream; zero once the index has run past a lowered total.
    always_comb
    begin
        if (index_reg < total_reg)
            remaining = total_reg - index_reg;
        else
            remaining = '0;

        if (index_reg >= pdmf_pkg::COUNT_W'(pdmf_pkg::FADE_LENGTH))
            index_clamp = pdmf_pkg::GAIN_W'(pdmf_pkg::FADE_LENGTH);
        else
            index_clamp = index_reg[pdmf_pkg::GAIN_W-1:0];

        if (remaining >= pdmf_pkg::COUNT_W'(pdmf_pkg::FADE_LENGTH))
            remain_clamp = pdmf_pkg::GAIN_W'(pdmf_pkg::FADE_LENGTH);
        else
            remain_clamp = remaining[pdmf_pkg::GAIN_W-1:0];

        last = ({1'b0, index_reg} + 25'd1) >= {1'b0, total_reg};

        fade.stereo = stereo_reg;
        fade.wide   = wide_reg;
        fade.gain   = (index_clamp < remain_clamp) ? index_clamp : remain_clamp;
        fade.last   = last;
    end

    always_comb
    begin
        index_next = index_reg;
        if (advance)
        begin
            if (last)
                index_next = '0;
            else
                index_next = index_reg + 24'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            wide_reg   <= 1'b0;
            total_reg  <= 24'd1;
            index_reg  <= '0;
        end
        else
        begin
            stereo_reg <= stereo_next;
            wide_reg   <= wide_next;
            total_reg  <= total_next;
            index_reg  <= index_next;
        end
    end

    `ASSERT_NEXT(a_wrap_to_zero, clk, rst_n, advance && last, index_reg == '0)
    `ASSERT_NEXT(a_count_up, clk, rst_n, advance && !last, index_reg == $past(index_reg) + 24'd1)
    `ASSERT_NEXT(a_total_write, clk, rst_n, write_enable && write_index == pdmf_pkg::REG_FRAME_TOTAL, total_reg == $past(write_data[pdmf_pkg::COUNT_W-1:0]))

endmodule

// File: rtl/pdmf_sample_path.sv
module pdmf_sample_path (
    input  logic                           clk,
    input  pdmf_pkg::stage_ctrl_t          stage,
    input  logic [pdmf_pkg::CHAN_W-1:0]    first_channel,
    input  logic [pdmf_pkg::CHAN_W-1:0]    second_channel,
    input  pdmf_pkg::fade_t                fade,
    output logic [pdmf_pkg::SAMPLE_W-1:0]  out_sample,
    output logic                           last_frame
);

    logic [pdmf_pkg::CHAN_W-1:0]    first_reg;
    logic [pdmf_pkg::CHAN_W-1:0]    second_reg;
    pdmf_pkg::fade_t                fade_reg;
    logic [pdmf_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [pdmf_pkg::SAMPLE_W-1:0]  sample_next;
    logic                           last_reg;

    logic signed [16:0]  wide_sum;
    logic signed [16:0]  wide_half;
    logic [8:0]          narrow_sum;
    logic [7:0]          decoded;
    logic signed [8:0]   centred;
    logic signed [8:0]   gain_s;
    logic signed [17:0]  product;
    logic signed [17:0]  rounded;
    logic [7:0]          scaled;

    always_comb
    begin
        wide_sum   = 17'(signed'(first_reg)) + 17'(signed'(second_reg));
        // The arithmetic shift rounds down, so a negative sum is bumped up by one first to truncate toward zero.
        if (fade_reg.stereo)
            wide_half = (wide_sum + 17'(wide_sum[16])) >>> 1;
        else
            wide_half = 17'(signed'(first_reg));

        narrow_sum = {1'b0, first_reg[7:0]} + {1'b0, second_reg[7:0]};

        // The high byte of a 16-bit value plus 128 is that byte with its sign bit flipped.
        if (fade_reg.wide)
            decoded = {~wide_half[15], wide_half[14:8]};
        else if (fade_reg.stereo)
            decoded = narrow_sum[8:1];
        else
            decoded = first_reg[7:0];

        centred = signed'({1'b0, decoded}) - 9'sd128;
        gain_s  = signed'(fade_reg.gain);
        product = centred * gain_s;
        rounded = product + (product[17] ? 18'sd255 : 18'sd0);
        scaled  = 8'(rounded >>> pdmf_pkg::FADE_SHIFT);

        if (fade_reg.gain[pdmf_pkg::GAIN_W-1])
            sample_next = decoded;
        else
            sample_next = pdmf_pkg::SILENCE + scaled;
    end

    always_ff @(posedge clk)
    begin
        if (stage.s1_load)
        begin
            first_reg  <= first_channel;
            second_reg <= second_channel;
            fade_reg   <= fade;
        end
        if (stage.s2_load)
        begin
            sample_reg <= sample_next;
            last_reg   <= fade_reg.last;
        end
    end

    assign out_sample = sample_reg;
    assign last_frame = last_reg;

endmodule

// File: rtl/pcm_downmix_fade_8bit.sv
// An accepted frame is captured in the first pipeline register, moves on to the
// result register when that one is free or draining, and its sample transfers from there.
// Throughput: one frame per cycle; the input stalls only when both pipeline
// registers are full and the sink holds ready low.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the
// frame counter and sets mono, 8-bit samples and a stream length of one frame.
`include "assert_macros.svh"

module pcm_downmix_fade_8bit (
    input  logic                          clk,
    input  logic                          rst_n,
    pdmf_in_if.sink                       frame,
    pdmf_out_if.source                    sample,
    input  logic                          write_enable,
    input  logic [pdmf_pkg::INDEX_W-1:0]  write_index,
    input  logic [pdmf_pkg::DATA_W-1:0]   write_data
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   accept;
    pdmf_pkg::stage_ctrl_t  stage;
    pdmf_pkg::fade_t        fade;

    always_comb
    begin
        s2_ready      = !s2_valid_reg || sample.ready;
        s1_ready      = !s1_valid_reg || s2_ready;
        accept        = frame.valid && s1_ready;
        stage.s1_load = accept;
        stage.s2_load = s1_valid_reg && s2_ready;

        s1_valid_next = s1_valid_reg;
        if (s1_ready)
            s1_valid_next = frame.valid;

        s2_valid_next = s2_valid_reg;
        if (s2_ready)
            s2_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    assign frame.ready  = s1_ready;
    assign sample.valid = s2_valid_reg;

    pdmf_frame_ctrl u_frame_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .advance      (accept),
        .fade         (fade)
    );

    pdmf_sample_path u_sample_path (
        .clk            (clk),
        .stage          (stage),
        .first_channel  (frame.first_channel),
        .second_channel (frame.second_channel),
        .fade           (fade),
        .out_sample     (sample.out_sample),
        .last_frame     (sample.last_frame)
    );

    `ASSERT_NEXT(a_s1_held, clk, rst_n, s1_valid_reg && !s2_ready, s1_valid_reg)
    `ASSERT_NEXT(a_s2_filled, clk, rst_n, stage.s2_load, s2_valid_reg)
    `ASSERT_NOW(a_empty_ready, clk, rst_n, !s1_valid_reg && !s2_valid_reg, frame.ready)

endmodule
